// ===== design/wsfd_pkg.sv =====
// Shared types and constants for the websocket frame deframer.
`default_nettype none
package wsfd_pkg;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic       ERR_NONE     = 1'b0;
  localparam logic       ERR_RSV      = 1'b1;

  localparam logic [6:0] LEN_EXT16    = 7'd126;
  localparam logic [6:0] LEN_EXT64    = 7'd127;

  localparam logic [2:0] EXT16_BYTES_M1 = 3'd1;
  localparam logic [2:0] EXT64_BYTES_M1 = 3'd7;
  localparam logic [2:0] KEY_BYTES_M1   = 3'd3;

  localparam logic [7:0] BYTE_ZERO    = 8'h00;

  typedef struct packed {
    logic [1:0]  kind;
    logic        fin_flag;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] frame_length;
    logic [7:0]  payload_byte;
    logic        error_code;
    logic        last;
  } result_t;

endpackage
`default_nettype wire

// ===== design/websocket_frame_deframer_unit.sv =====
// Top level of the websocket frame deframer.
// Takes one stream byte per transfer and parses websocket frames: header
// bytes give no record except the one that completes the header, which gives
// a header record; each payload byte then gives one unmasked payload record,
// the final one flagged last. Reserved bits set in header byte zero give an
// error record for that byte and every later byte until reset. One byte is
// accepted every cycle while the result side is not stalled; a byte's record
// is offered after it passes the input register, then the parser logic into
// the result register. in_stall_o rises only when the input register is full
// and the result register is held by out_stall_i.
`default_nettype none
module websocket_frame_deframer_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [1:0]  kind_o,
  output logic        fin_flag_o,
  output logic [3:0]  opcode_o,
  output logic        masked_o,
  output logic [63:0] frame_length_o,
  output logic [7:0]  payload_byte_o,
  output logic        error_code_o,
  output logic        last_o
);
  import wsfd_pkg::*;

  logic       out_free;
  logic       step;
  logic [7:0] byte_s1;
  logic       res_vld;
  result_t    res;
  result_t    res_out;

  wsfd_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .out_free_i  (out_free),
    .step_o      (step),
    .byte_o      (byte_s1)
  );

  wsfd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .byte_i    (byte_s1),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  wsfd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_vld),
    .res_i       (res),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign kind_o         = res_out.kind;
  assign fin_flag_o     = res_out.fin_flag;
  assign opcode_o       = res_out.opcode;
  assign masked_o       = res_out.masked;
  assign frame_length_o = res_out.frame_length;
  assign payload_byte_o = res_out.payload_byte;
  assign error_code_o   = res_out.error_code;
  assign last_o         = res_out.last;

endmodule
`default_nettype wire

// ===== design/wsfd_in_reg.sv =====
// Input register stage: holds one accepted stream byte until the parser takes it.
`default_nettype none
module wsfd_in_reg (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire  [7:0] data_byte_i,
  input  wire        out_free_i,
  output logic       step_o,
  output logic [7:0] byte_o
);
  import wsfd_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       accept;

  assign step_o     = valid_q && out_free_i;
  assign in_stall_o = valid_q && !out_free_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign byte_o     = byte_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (step_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= data_byte_i;
    end
  end

endmodule
`default_nettype wire

// ===== design/wsfd_parser.sv =====
// Frame header state machine, length and key capture, payload unmasking.
`default_nettype none
module wsfd_parser (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   step_i,
  input  wire  [7:0]            byte_i,
  output logic                  res_vld_o,
  output wsfd_pkg::result_t     res_o
);
  import wsfd_pkg::*;

  typedef enum logic [2:0] {
    PH_BYTE0   = 3'd0,
    PH_BYTE1   = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_ERROR   = 3'd5
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        fin_q, fin_d;
  logic [3:0]  opc_q, opc_d;
  logic        mask_q, mask_d;
  logic [63:0] total_q, total_d;
  logic [63:0] rem_q, rem_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  kidx_q, kidx_d;
  logic        hdr_done;
  logic        last_byte;
  logic [7:0]  key_byte;

  always_comb begin
    unique case (kidx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  assign last_byte = (rem_q[63:1] == 63'd0);

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    fin_d     = fin_q;
    opc_d     = opc_q;
    mask_d    = mask_q;
    total_d   = total_q;
    rem_d     = rem_q;
    key_d     = key_q;
    kidx_d    = kidx_q;
    hdr_done  = 1'b0;
    res_vld_o = 1'b0;
    res_o          = '0;
    res_o.fin_flag = fin_q;
    res_o.opcode   = opc_q;

    if (step_i) begin
      unique case (phase_q)
        PH_BYTE1: begin
          mask_d  = byte_i[7];
          total_d = 64'd0;
          if (byte_i[6:0] == LEN_EXT16) begin
            cnt_d   = EXT16_BYTES_M1;
            phase_d = PH_EXTLEN;
          end else if (byte_i[6:0] == LEN_EXT64) begin
            cnt_d   = EXT64_BYTES_M1;
            phase_d = PH_EXTLEN;
          end else begin
            total_d = {57'd0, byte_i[6:0]};
            if (byte_i[7]) begin
              cnt_d   = KEY_BYTES_M1;
              phase_d = PH_KEY;
            end else begin
              hdr_done = 1'b1;
            end
          end
        end
        PH_EXTLEN: begin
          total_d = {total_q[55:0], byte_i};
          if (cnt_q != 3'd0) begin
            cnt_d = cnt_q - 3'd1;
          end else if (mask_q) begin
            cnt_d   = KEY_BYTES_M1;
            phase_d = PH_KEY;
          end else begin
            hdr_done = 1'b1;
          end
        end
        PH_KEY: begin
          key_d = {key_q[23:0], byte_i};
          if (cnt_q != 3'd0) begin
            cnt_d = cnt_q - 3'd1;
          end else begin
            hdr_done = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          res_vld_o          = 1'b1;
          res_o.kind         = KIND_PAYLOAD;
          res_o.masked       = mask_q;
          res_o.frame_length = total_q;
          res_o.payload_byte = byte_i ^ (mask_q ? key_byte : BYTE_ZERO);
          res_o.error_code   = ERR_NONE;
          res_o.last         = last_byte;
          if (rem_q != 64'd0) begin
            rem_d = rem_q - 64'd1;
          end
          kidx_d = kidx_q + 2'd1;
          if (last_byte) begin
            rem_d   = 64'd0;
            phase_d = PH_BYTE0;
          end
        end
        PH_ERROR: begin
          res_vld_o        = 1'b1;
          res_o.kind       = KIND_ERROR;
          res_o.error_code = ERR_RSV;
        end
        default: begin
          fin_d = byte_i[7];
          opc_d = byte_i[3:0];
          cnt_d = 3'd0;
          if (byte_i[6:4] != 3'd0) begin
            phase_d          = PH_ERROR;
            res_vld_o        = 1'b1;
            res_o.kind       = KIND_ERROR;
            res_o.fin_flag   = byte_i[7];
            res_o.opcode     = byte_i[3:0];
            res_o.error_code = ERR_RSV;
          end else begin
            phase_d = PH_BYTE1;
          end
        end
      endcase

      if (hdr_done) begin
        rem_d              = total_d;
        kidx_d             = 2'd0;
        res_vld_o          = 1'b1;
        res_o.kind         = KIND_HEADER;
        res_o.masked       = mask_d;
        res_o.frame_length = total_d;
        res_o.error_code   = ERR_NONE;
        res_o.last         = (total_d == 64'd0);
        phase_d            = (total_d == 64'd0) ? PH_BYTE0 : PH_PAYLOAD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_BYTE0;
      cnt_q   <= 3'd0;
      fin_q   <= 1'b0;
      opc_q   <= 4'd0;
      mask_q  <= 1'b0;
      total_q <= 64'd0;
      rem_q   <= 64'd0;
      key_q   <= 32'd0;
      kidx_q  <= 2'd0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      fin_q   <= fin_d;
      opc_q   <= opc_d;
      mask_q  <= mask_d;
      total_q <= total_d;
      rem_q   <= rem_d;
      key_q   <= key_d;
      kidx_q  <= kidx_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/wsfd_out_reg.sv =====
// Result register: holds one record until the downstream side takes it.
`default_nettype none
module wsfd_out_reg (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   load_i,
  input  wsfd_pkg::result_t     res_i,
  output logic                  out_free_o,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output wsfd_pkg::result_t     res_o
);
  import wsfd_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign out_free_o  = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_free_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule
`default_nettype wire

// ===== design/wsfd_checker.sv =====
// Port-level checks for the websocket frame deframer, bound to the top level.
`default_nettype none
module wsfd_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire [1:0]  kind_o,
  input wire        masked_o,
  input wire [63:0] frame_length_o,
  input wire [7:0]  payload_byte_o,
  input wire        error_code_o,
  input wire        last_o
);
  import wsfd_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
      $stable(payload_byte_o) && $stable(frame_length_o) && $stable(last_o))
    else $error("stalled result changed");

  a_err_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_ERROR |-> error_code_o == ERR_RSV && !masked_o &&
      frame_length_o == 64'd0 && payload_byte_o == BYTE_ZERO && !last_o)
    else $error("malformed error record");

  a_hdr_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_HEADER |-> error_code_o == ERR_NONE &&
      payload_byte_o == BYTE_ZERO && last_o == (frame_length_o == 64'd0))
    else $error("malformed header record");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_ERROR |=> !out_valid_o || kind_o == KIND_ERROR)
    else $error("error state left without reset");

  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> kind_o == KIND_HEADER || kind_o == KIND_PAYLOAD ||
      kind_o == KIND_ERROR)
    else $error("undefined record kind");

endmodule

bind websocket_frame_deframer_unit wsfd_checker u_wsfd_checker (.*);
`default_nettype wire
